@@ src/clfr_pkg.sv @@
package clfr_pkg;

   localparam int LINE_PIXELS   = 2048;
   localparam int MAX_FRAGMENTS = 8;
   localparam int PLACE_W       = $clog2(LINE_PIXELS);

   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   localparam logic       OP_WRITE = 1'b0;
   localparam logic       OP_READ  = 1'b1;

   localparam logic [7:0] COLOR_RED   = 8'd0;
   localparam logic [7:0] COLOR_GREEN = 8'd1;
   localparam logic [7:0] COLOR_BLUE  = 8'd2;

   localparam logic [1:0] CSR_FRAGMENTS_PER_LINE = 2'd0;
   localparam logic [1:0] CSR_BYTES_PER_FRAGMENT = 2'd1;

   localparam logic [3:0]  FRAGMENTS_PER_LINE_RST = 4'd8;
   localparam logic [11:0] BYTES_PER_FRAGMENT_RST = 12'd256;

   typedef struct packed {
      logic               is_read;
      logic               drop;
      logic               complete;
      logic [1:0]         color;
      logic [PLACE_W-1:0] place;
      logic [7:0]         pix;
   } cmd_type;

   typedef struct packed {
      logic       complete;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drop;
   } rsp_type;

endpackage

@@ src/clfr_ram.sv @@
module clfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/clfr_front.sv @@
module clfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  req_op,
   input  logic [31:0]           req_line_number,
   input  logic [7:0]            req_fragment_number,
   input  logic [7:0]            req_color_code,
   input  logic [10:0]           req_byte_place,
   input  logic [7:0]            req_pixel_byte,
   input  logic                  req_fragment_end,
   input  logic [10:0]           req_read_place,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_data,
   output clfr_pkg::cmd_type     cmd
);

   logic [3:0]  fpl_ff, fpl_in;
   logic [11:0] bpf_ff, bpf_in;
   logic [31:0] cur_line_ff, cur_line_in;
   logic [2:0]  marks_ff [clfr_pkg::MAX_FRAGMENTS];
   logic [2:0]  marks_in [clfr_pkg::MAX_FRAGMENTS];

   logic        is_write;
   logic        line_new;
   logic [19:0] prod;
   logic [20:0] place_sum;
   logic        bad_color, bad_frag, bad_place, wr_drop, rd_drop;
   logic        complete;

   assign csr_ready = 1'b1;

   always_comb begin
      fpl_in = fpl_ff;
      bpf_in = bpf_ff;
      if (csr_valid) begin
         case (csr_index)
            clfr_pkg::CSR_FRAGMENTS_PER_LINE: fpl_in = csr_data[3:0];
            clfr_pkg::CSR_BYTES_PER_FRAGMENT: bpf_in = csr_data;
            default: ;
         endcase
      end
   end

   assign is_write  = accept && (req_op == clfr_pkg::OP_WRITE);
   assign line_new  = req_line_number != cur_line_ff;
   assign prod      = 20'(req_fragment_number) * 20'(bpf_ff);
   assign place_sum = 21'(prod) + 21'(req_byte_place);
   assign bad_color = req_color_code > clfr_pkg::COLOR_BLUE;
   assign bad_frag  = 32'(req_fragment_number) >= clfr_pkg::MAX_FRAGMENTS;
   assign bad_place = 32'(place_sum) >= clfr_pkg::LINE_PIXELS;
   assign wr_drop   = bad_color || bad_frag || bad_place;
   assign rd_drop   = 32'(req_read_place) >= clfr_pkg::LINE_PIXELS;

   assign cur_line_in = is_write ? req_line_number : cur_line_ff;

   always_comb begin
      for (int i = 0; i < clfr_pkg::MAX_FRAGMENTS; i++) begin
         marks_in[i] = (is_write && line_new) ? 3'b000 : marks_ff[i];
         if (is_write && !wr_drop && req_fragment_end &&
             32'(req_fragment_number) == 32'(i)) begin
            marks_in[i][req_color_code[1:0]] = 1'b1;
         end
      end
   end

   // fragments_per_line of zero counts as one
   always_comb begin
      complete = 1'b1;
      for (int i = 0; i < clfr_pkg::MAX_FRAGMENTS; i++) begin
         if (((i == 0) || (32'(fpl_ff) > 32'(i))) && (marks_in[i] != 3'b111)) begin
            complete = 1'b0;
         end
      end
   end

   always_comb begin
      cmd.is_read  = req_op == clfr_pkg::OP_READ;
      cmd.drop     = (req_op == clfr_pkg::OP_READ) ? rd_drop : wr_drop;
      cmd.complete = complete;
      cmd.color    = req_color_code[1:0];
      cmd.place    = (req_op == clfr_pkg::OP_READ) ?
                     req_read_place[clfr_pkg::PLACE_W-1:0] :
                     place_sum[clfr_pkg::PLACE_W-1:0];
      cmd.pix      = req_pixel_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpl_ff      <= clfr_pkg::FRAGMENTS_PER_LINE_RST;
         bpf_ff      <= clfr_pkg::BYTES_PER_FRAGMENT_RST;
         cur_line_ff <= '0;
         for (int i = 0; i < clfr_pkg::MAX_FRAGMENTS; i++) begin
            marks_ff[i] <= '0;
         end
      end else begin
         fpl_ff      <= fpl_in;
         bpf_ff      <= bpf_in;
         cur_line_ff <= cur_line_in;
         for (int i = 0; i < clfr_pkg::MAX_FRAGMENTS; i++) begin
            marks_ff[i] <= marks_in[i];
         end
      end
   end

endmodule

@@ src/clfr_cmd_queue.sv @@
module clfr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clfr_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output clfr_pkg::cmd_type head
);

   clfr_pkg::cmd_type              slot_ff [clfr_pkg::CMD_DEPTH];
   logic [clfr_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [clfr_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [clfr_pkg::CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           do_pop;

   assign full   = 32'(cnt_ff) == clfr_pkg::CMD_DEPTH;
   assign valid  = cnt_ff != '0;
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == clfr_pkg::CMD_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == clfr_pkg::CMD_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + clfr_pkg::CMD_CNT_W'(push) - clfr_pkg::CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ src/clfr_back.sv @@
module clfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  clfr_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output clfr_pkg::rsp_type rsp
);

   logic                           take;
   logic                           wr_ok;
   logic [7:0]                     red_q, green_q, blue_q;
   logic                           s1_valid_ff;
   clfr_pkg::cmd_type              s1_cmd_ff;
   clfr_pkg::rsp_type              s1_rsp;

   clfr_pkg::rsp_type              rsp_slot_ff [clfr_pkg::RSP_DEPTH];
   logic [clfr_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [clfr_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [clfr_pkg::RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           do_pop;

   // reserve room for the transfer still in the read stage
   assign take    = cmd_valid &&
                    ((32'(cnt_ff) + 32'(s1_valid_ff)) < clfr_pkg::RSP_DEPTH);
   assign cmd_pop = take;
   assign wr_ok   = take && !cmd.is_read && !cmd.drop;

   clfr_ram #(.WIDTH(8), .DEPTH(clfr_pkg::LINE_PIXELS)) u_red (
      .clock (clock),
      .we    (wr_ok && (cmd.color == clfr_pkg::COLOR_RED[1:0])),
      .waddr (cmd.place),
      .wdata (cmd.pix),
      .raddr (cmd.place),
      .rdata (red_q)
   );

   clfr_ram #(.WIDTH(8), .DEPTH(clfr_pkg::LINE_PIXELS)) u_green (
      .clock (clock),
      .we    (wr_ok && (cmd.color == clfr_pkg::COLOR_GREEN[1:0])),
      .waddr (cmd.place),
      .wdata (cmd.pix),
      .raddr (cmd.place),
      .rdata (green_q)
   );

   clfr_ram #(.WIDTH(8), .DEPTH(clfr_pkg::LINE_PIXELS)) u_blue (
      .clock (clock),
      .we    (wr_ok && (cmd.color == clfr_pkg::COLOR_BLUE[1:0])),
      .waddr (cmd.place),
      .wdata (cmd.pix),
      .raddr (cmd.place),
      .rdata (blue_q)
   );

   always_comb begin
      s1_rsp.complete = s1_cmd_ff.complete;
      s1_rsp.drop     = s1_cmd_ff.drop;
      if (s1_cmd_ff.is_read && !s1_cmd_ff.drop) begin
         s1_rsp.red   = red_q;
         s1_rsp.green = green_q;
         s1_rsp.blue  = blue_q;
      end else begin
         s1_rsp.red   = '0;
         s1_rsp.green = '0;
         s1_rsp.blue  = '0;
      end
   end

   assign rsp_empty = cnt_ff == '0;
   assign rsp       = rsp_slot_ff[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (32'(wr_ptr_ff) == clfr_pkg::RSP_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == clfr_pkg::RSP_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + clfr_pkg::RSP_CNT_W'(s1_valid_ff) - clfr_pkg::RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= cmd;
      if (s1_valid_ff) begin
         rsp_slot_ff[wr_ptr_ff] <= s1_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= take;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

@@ src/color_line_fragment_reassembly_core.sv @@
// Color line fragment reassembly.
// Request queue: drive req_* fields with req_push; a transfer happens on a clock
// edge with req_push high and req_full low. op write stores one pixel byte of a
// red, green or blue fragment and updates the per-fragment received marks; op
// read returns the three stored bytes at req_read_place.
// Response queue: while rsp_empty is low the oldest response is on rsp_*; it is
// taken on an edge with rsp_pop high. Every request gives exactly one response.
// CSR port: csr_index 0 is fragments_per_line, 1 is bytes_per_fragment; csr_ready
// is always high. Write only while no request is in flight.
// Throughput: one request per cycle while req_full is low. The front stage
// classifies and updates the marks in the accept cycle; the back stage writes
// one plane RAM or reads all three per command. A request passes the command
// queue, then the registered RAM read, into the response queue.
// Stall: the response queue holds four entries; when full, the back stage stops,
// the two-entry command queue fills and req_full rises.
// Reset: synchronous; clears both queues, the marks, the current line number and
// restores the CSR defaults. Plane contents stay undefined until written.
module color_line_fragment_reassembly_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_op,
   input  logic [31:0] req_line_number,
   input  logic [7:0]  req_fragment_number,
   input  logic [7:0]  req_color_code,
   input  logic [10:0] req_byte_place,
   input  logic [7:0]  req_pixel_byte,
   input  logic        req_fragment_end,
   input  logic [10:0] req_read_place,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_all_received,
   output logic [7:0]  rsp_red_value,
   output logic [7:0]  rsp_green_value,
   output logic [7:0]  rsp_blue_value,
   output logic        rsp_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic              accept;
   logic              cmd_valid;
   logic              cmd_pop;
   clfr_pkg::cmd_type front_cmd;
   clfr_pkg::cmd_type head_cmd;
   clfr_pkg::rsp_type rsp;

   assign accept = req_push && !req_full;

   clfr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_op              (req_op),
      .req_line_number     (req_line_number),
      .req_fragment_number (req_fragment_number),
      .req_color_code      (req_color_code),
      .req_byte_place      (req_byte_place),
      .req_pixel_byte      (req_pixel_byte),
      .req_fragment_end    (req_fragment_end),
      .req_read_place      (req_read_place),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (front_cmd)
   );

   clfr_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .valid    (cmd_valid),
      .head     (head_cmd)
   );

   clfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_all_received = rsp.complete;
   assign rsp_red_value    = rsp.red;
   assign rsp_green_value  = rsp.green;
   assign rsp_blue_value   = rsp.blue;
   assign rsp_dropped      = rsp.drop;

endmodule

@@ src/clfr_checker.sv @@
module clfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_all_received,
   input logic [7:0]  rsp_red_value,
   input logic [7:0]  rsp_green_value,
   input logic [7:0]  rsp_blue_value,
   input logic        rsp_dropped
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_dropped) |->
         (rsp_red_value == 8'd0 && rsp_green_value == 8'd0 && rsp_blue_value == 8'd0))
      else $error("dropped response carries pixel data");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_red_value) && $stable(rsp_green_value) &&
          $stable(rsp_blue_value) && $stable(rsp_dropped) && $stable(rsp_all_received)))
      else $error("stalled response changed");

endmodule

bind color_line_fragment_reassembly_core clfr_checker u_clfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_all_received (rsp_all_received),
   .rsp_red_value    (rsp_red_value),
   .rsp_green_value  (rsp_green_value),
   .rsp_blue_value   (rsp_blue_value),
   .rsp_dropped      (rsp_dropped)
);

@@ tb/color_line_fragment_reassembly_core_tb.sv @@
`timescale 1ns / 1ps

module color_line_fragment_reassembly_core_tb;

   localparam int PHASES       = 10;
   localparam int RANDOM_ITEMS = 1450;

   typedef struct {
      logic        op;
      logic [31:0] line;
      logic [7:0]  frag;
      logic [7:0]  color;
      logic [10:0] bplace;
      logic [7:0]  pix;
      logic        fend;
      logic [10:0] rplace;
   } pixel_request_type;

   class reassembly_scoreboard;
      logic [3:0]        frag_count;
      logic [11:0]       frag_bytes;
      logic [31:0]       line_id;
      logic [2:0]        marks [clfr_pkg::MAX_FRAGMENTS];
      logic [7:0]        plane [3][clfr_pkg::LINE_PIXELS];
      bit                stored [3][clfr_pkg::LINE_PIXELS];
      int                known_places[$];
      clfr_pkg::rsp_type pixel_answers[$];
      int                mismatches;

      function new();
         frag_count = clfr_pkg::FRAGMENTS_PER_LINE_RST;
         frag_bytes = clfr_pkg::BYTES_PER_FRAGMENT_RST;
         line_id    = '0;
         foreach (marks[i]) marks[i] = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [11:0] val);
         if (idx == clfr_pkg::CSR_FRAGMENTS_PER_LINE) frag_count = val[3:0];
         else if (idx == clfr_pkg::CSR_BYTES_PER_FRAGMENT) frag_bytes = val;
      endfunction

      function int pending();
         return pixel_answers.size();
      endfunction

      function int fragment_target();
         if (frag_count == 0) return 1;
         if (frag_count > clfr_pkg::MAX_FRAGMENTS) return clfr_pkg::MAX_FRAGMENTS;
         return int'(frag_count);
      endfunction

      function bit line_done();
         for (int i = 0; i < fragment_target(); i++) begin
            if (marks[i] != 3'b111) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(pixel_request_type r);
         clfr_pkg::rsp_type ans;
         int                place;
         int                c;
         ans = '0;
         if (r.op == clfr_pkg::OP_WRITE) begin
            if (r.line != line_id) begin
               line_id = r.line;
               foreach (marks[i]) marks[i] = '0;
            end
            place = int'(r.frag) * int'(frag_bytes) + int'(r.bplace);
            if (r.color > clfr_pkg::COLOR_BLUE || r.frag >= clfr_pkg::MAX_FRAGMENTS ||
                place >= clfr_pkg::LINE_PIXELS) begin
               ans.drop = 1'b1;
            end else begin
               c = int'(r.color);
               plane[c][place] = r.pix;
               if (!stored[c][place]) begin
                  stored[c][place] = 1'b1;
                  if (stored[clfr_pkg::COLOR_RED][place] &&
                      stored[clfr_pkg::COLOR_GREEN][place] &&
                      stored[clfr_pkg::COLOR_BLUE][place])
                     known_places.push_back(place);
               end
               if (r.fend) marks[r.frag] = marks[r.frag] | (3'b001 << c);
            end
         end else if (r.rplace < clfr_pkg::LINE_PIXELS) begin
            ans.red   = plane[clfr_pkg::COLOR_RED][r.rplace];
            ans.green = plane[clfr_pkg::COLOR_GREEN][r.rplace];
            ans.blue  = plane[clfr_pkg::COLOR_BLUE][r.rplace];
         end else begin
            ans.drop = 1'b1;
         end
         ans.complete = line_done();
         pixel_answers.push_back(ans);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(clfr_pkg::rsp_type got);
         clfr_pkg::rsp_type want;
         if (pixel_answers.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none actual %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = pixel_answers.pop_front();
         compare_field("all_received", 8'(want.complete), 8'(got.complete));
         compare_field("red_value", want.red, got.red);
         compare_field("green_value", want.green, got.green);
         compare_field("blue_value", want.blue, got.blue);
         compare_field("dropped", 8'(want.drop), 8'(got.drop));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_op;
   logic [31:0] req_line_number;
   logic [7:0]  req_fragment_number;
   logic [7:0]  req_color_code;
   logic [10:0] req_byte_place;
   logic [7:0]  req_pixel_byte;
   logic        req_fragment_end;
   logic [10:0] req_read_place;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_all_received;
   logic [7:0]  rsp_red_value;
   logic [7:0]  rsp_green_value;
   logic [7:0]  rsp_blue_value;
   logic        rsp_dropped;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   reassembly_scoreboard board;
   clfr_pkg::rsp_type    seen;
   bit                   calm;
   int                   idle_pct;
   int                   stall_pct;
   int                   items_sent;

   int phase_fpl [PHASES] = '{1, 0, 15, 8, 4, 2, 8, 6, 3, 8};
   int phase_bpf [PHASES] = '{1, 0, 4095, 2048, 3, 256, 256, 2, 2047, 4};

   color_line_fragment_reassembly_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_op              (req_op),
      .req_line_number     (req_line_number),
      .req_fragment_number (req_fragment_number),
      .req_color_code      (req_color_code),
      .req_byte_place      (req_byte_place),
      .req_pixel_byte      (req_pixel_byte),
      .req_fragment_end    (req_fragment_end),
      .req_read_place      (req_read_place),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_all_received    (rsp_all_received),
      .rsp_red_value       (rsp_red_value),
      .rsp_green_value     (rsp_green_value),
      .rsp_blue_value      (rsp_blue_value),
      .rsp_dropped         (rsp_dropped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #10 clock = ~clock;

   function automatic pixel_request_type random_item();
      pixel_request_type r;
      r.op     = 1'($urandom_range(0, 1));
      r.line   = $urandom();
      r.frag   = 8'($urandom());
      r.color  = 8'($urandom());
      r.bplace = 11'($urandom());
      r.pix    = 8'($urandom());
      r.fend   = 1'($urandom_range(0, 1));
      r.rplace = 11'($urandom());
      return r;
   endfunction

   function automatic pixel_request_type write_req(logic [31:0] line, logic [7:0] frag,
                                                   logic [7:0] color, logic [10:0] bplace,
                                                   logic [7:0] pix, logic fend);
      pixel_request_type r;
      r        = random_item();
      r.op     = clfr_pkg::OP_WRITE;
      r.line   = line;
      r.frag   = frag;
      r.color  = color;
      r.bplace = bplace;
      r.pix    = pix;
      r.fend   = fend;
      return r;
   endfunction

   function automatic pixel_request_type read_req(logic [10:0] place);
      pixel_request_type r;
      r        = random_item();
      r.op     = clfr_pkg::OP_READ;
      r.rplace = place;
      return r;
   endfunction

   task automatic push_request(pixel_request_type r);
      @(negedge clock);
      req_op              = r.op;
      req_line_number     = r.line;
      req_fragment_number = r.frag;
      req_color_code      = r.color;
      req_byte_place      = r.bplace;
      req_pixel_byte      = r.pix;
      req_fragment_end    = r.fend;
      req_read_place      = r.rplace;
      req_push            = 1'b1;
      do @(posedge clock); while (req_full);
      board.note_request(r);
      items_sent++;
   endtask

   task automatic issue(pixel_request_type r);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_push = 1'b0;
         end
      end
      push_request(r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_push = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [11:0] val);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_read();
      if (board.known_places.size() == 0) return;
      issue(read_req(11'(board.known_places[$urandom_range(0,
                                            board.known_places.size() - 1)])));
   endtask

   task automatic send_fragment(logic [31:0] line, int frag, int color);
      int limit;
      int k;
      int start;
      limit = (board.frag_bytes == 0) ? 1 : int'(board.frag_bytes);
      if (limit > clfr_pkg::LINE_PIXELS) limit = clfr_pkg::LINE_PIXELS;
      k = $urandom_range(1, 4);
      if (k > limit) k = limit;
      start = ($urandom_range(0, 1) == 0 || limit == k) ? 0 : $urandom_range(0, limit - k);
      for (int b = 0; b < k; b++) begin
         // occasionally the closing byte loses its end mark
         issue(write_req(line, 8'(frag), 8'(color), 11'(start + b), 8'($urandom()),
                         (b == k - 1) && ($urandom_range(0, 14) != 0)));
      end
   endtask

   task automatic send_line();
      logic [31:0]       line;
      int                slots[$];
      int                n;
      int                skip;
      int                j;
      int                tmp;
      pixel_request_type r;
      line = ($urandom_range(0, 3) == 0) ? board.line_id : $urandom();
      n = board.fragment_target();
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, clfr_pkg::MAX_FRAGMENTS);
      for (int s = 0; s < 3 * n; s++) slots.push_back(s);
      for (int s = slots.size() - 1; s > 0; s--) begin
         j        = $urandom_range(0, s);
         tmp      = slots[s];
         slots[s] = slots[j];
         slots[j] = tmp;
      end
      skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, slots.size() - 1) : -1;
      foreach (slots[s]) begin
         if (s == skip) continue;
         send_fragment(line, slots[s] / 3, slots[s] % 3);
         case ($urandom_range(0, 19))
            0: begin
               r    = random_item();
               r.op = clfr_pkg::OP_WRITE;
               if ($urandom_range(0, 3) != 0) r.line = line;
               issue(r);
            end
            1: send_read();
            2: line = $urandom();
            default: ;
         endcase
      end
      repeat ($urandom_range(1, 4)) send_read();
   endtask

   initial begin
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         seen.complete = rsp_all_received;
         seen.red      = rsp_red_value;
         seen.green    = rsp_green_value;
         seen.blue     = rsp_blue_value;
         seen.drop     = rsp_dropped;
         board.check_response(seen);
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int goal;
      reset               = 1'b1;
      req_push            = 1'b0;
      req_op              = clfr_pkg::OP_WRITE;
      req_line_number     = '0;
      req_fragment_number = '0;
      req_color_code      = '0;
      req_byte_place      = '0;
      req_pixel_byte      = '0;
      req_fragment_end    = 1'b0;
      req_read_place      = '0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      calm                = 1'b0;
      idle_pct            = 0;
      stall_pct           = 0;
      items_sent          = 0;
      board               = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      issue(write_req(32'h0, 8'd0, clfr_pkg::COLOR_RED, 11'd0, 8'h00, 1'b0));
      issue(write_req(32'h0, 8'd0, clfr_pkg::COLOR_GREEN, 11'd0, 8'hFF, 1'b0));
      issue(write_req(32'h0, 8'd0, clfr_pkg::COLOR_BLUE, 11'd0, 8'hA5, 1'b1));
      issue(read_req(11'd0));
      // unknown colors
      issue(write_req(32'h0, 8'd0, 8'd3, 11'd0, 8'h11, 1'b1));
      issue(write_req(32'h0, 8'd0, 8'hFF, 11'd5, 8'h22, 1'b1));
      // fragment past the table, place past the line
      issue(write_req(32'h0, 8'd8, clfr_pkg::COLOR_RED, 11'd0, 8'h33, 1'b1));
      issue(write_req(32'h0, 8'hFF, clfr_pkg::COLOR_GREEN, 11'h7FF, 8'h44, 1'b1));
      issue(write_req(32'h0, 8'd7, clfr_pkg::COLOR_BLUE, 11'h7FF, 8'h55, 1'b1));
      // last pixel of the line, new line number
      issue(write_req(32'hFFFF_FFFF, 8'd7, clfr_pkg::COLOR_RED, 11'd255, 8'hFF, 1'b1));
      issue(write_req(32'hFFFF_FFFF, 8'd7, clfr_pkg::COLOR_GREEN, 11'd255, 8'h80, 1'b1));
      issue(write_req(32'hFFFF_FFFF, 8'd7, clfr_pkg::COLOR_BLUE, 11'd255, 8'h01, 1'b1));
      issue(read_req(11'h7FF));
      // dropped write still switches the line
      issue(write_req(32'h1234_5678, 8'd0, 8'd7, 11'd0, 8'h00, 1'b1));
      // byte past the fragment size but inside the line
      issue(write_req(32'h1234_5678, 8'd0, clfr_pkg::COLOR_RED, 11'd300, 8'h5A, 1'b1));
      issue(read_req(11'd0));

      for (int p = 0; p < PHASES; p++) begin
         write_csr(clfr_pkg::CSR_FRAGMENTS_PER_LINE, 12'(phase_fpl[p]));
         write_csr(clfr_pkg::CSR_BYTES_PER_FRAGMENT, 12'(phase_bpf[p]));
         calm      = (p == PHASES - 1);
         idle_pct  = 15 * $urandom_range(0, 2);
         stall_pct = 15 * $urandom_range(0, 2);
         goal      = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < goal) send_line();
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ color_line_fragment_reassembly_core.f @@
src/clfr_pkg.sv
src/clfr_ram.sv
src/clfr_front.sv
src/clfr_cmd_queue.sv
src/clfr_back.sv
src/color_line_fragment_reassembly_core.sv
src/clfr_checker.sv
tb/color_line_fragment_reassembly_core_tb.sv
